>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg
// Field widths, operation and status codes for the slot registry.
// ----------------------------------------------------------------------------
package lfs_pkg;

  // Transaction field widths
  localparam int IDX_W  = 10;
  localparam int TYPE_W = 2;
  localparam int OUT_W  = 11;
  localparam int ST_W   = 2;

  // Valid-bit row geometry
  localparam int W  = 32;
  localparam int OW = 5;

  // "No object" marker on freed_index
  localparam logic [OUT_W-1:0] NONE_INDEX = 11'd1024;

  // Operation codes
  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_DISPOSE  = 1'b1;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FREE  = 2'd3;

  // Entry memory word: object type over object index
  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [IDX_W-1:0]  obj;
  } entry_t;

endpackage

>>> design/lfs_zero_find.sv
// ----------------------------------------------------------------------------
// lfs_zero_find
// Priority encoder: position of the lowest clear bit of a vector.
// ----------------------------------------------------------------------------
module lfs_zero_find #(
  parameter int N = 32
) (
  input  logic [N-1:0]                        bits,
  output logic                                found,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] index
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  // Scan from the top so the lowest clear bit wins
  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        found = 1'b1;
        index = IW'(i);
      end
    end
  end

endmodule

>>> design/lowest_free_slot_registry.sv
// ----------------------------------------------------------------------------
// lowest_free_slot_registry
// Slot table with lowest-free allocation and dispose by slot number.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | op, item_index, obj_type
//  out     | output    | out_valid / out_stall| slot, freed_index, status
//
//  A dispose passes through accept and then the read state for the valid-row
//  and entry memory reads. A register does the same, plus a scan state when
//  the next free slot lies in a higher valid row, which costs a second row read.
//  One transaction is in work at a time; a finished result waits in the
//  output register while the next transaction is accepted.
//  Reset needs no clearing pass: per-row init flags make untouched rows read
//  as all free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lowest_free_slot_registry
  import lfs_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [IDX_W-1:0]  item_index,
  input  logic [TYPE_W-1:0] obj_type,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  slot,
  output logic [OUT_W-1:0]  freed_index,
  output logic [ST_W-1:0]   status
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int ROWS = (SLOTS + W - 1) / W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  // Bits of a row past the last slot count as occupied
  function automatic logic [W-1:0] pad_mask(input logic [RW-1:0] r);
    logic [W-1:0] m;
    for (int i = 0; i < W; i++) begin
      m[i] = ((32'(r) * W + i) >= SLOTS);
    end
    return m;
  endfunction

  // Bits at or below an offset
  function automatic logic [W-1:0] low_mask(input logic [OW-1:0] off);
    logic [W-1:0] m;
    for (int i = 0; i < W; i++) begin
      m[i] = (i <= int'(off));
    end
    return m;
  endfunction

  function automatic logic [RW-1:0] row_of(input logic [SW-1:0] s);
    logic [31:0] t;
    t = 32'(s) >> OW;
    return t[RW-1:0];
  endfunction

  function automatic logic [OW-1:0] off_of(input logic [SW-1:0] s);
    logic [31:0] t;
    t = 32'(s);
    return t[OW-1:0];
  endfunction

  function automatic logic [CW-1:0] slot_at(input logic [RW-1:0] r,
                                            input logic [OW-1:0] off);
    logic [31:0] t;
    t = (32'(r) << OW) | 32'(off);
    return t[CW-1:0];
  endfunction

  // Control state
  logic [1:0]      state;
  logic [CW-1:0]   lowest_free;
  logic [CW-1:0]   used_count;
  logic [ROWS-1:0] row_full;
  logic [ROWS-1:0] row_init;

  // Request held for the transaction in work
  logic              op_q;
  logic [SW-1:0]     req_slot;
  logic              req_ok;
  logic [IDX_W-1:0]  idx_q;
  logic [TYPE_W-1:0] type_q;
  logic [RW-1:0]     scan_row;

  // Result held while the output register is busy
  logic [OUT_W-1:0] res_slot;
  logic [OUT_W-1:0] res_freed;
  logic [ST_W-1:0]  res_status;

  // Memories and their registered read data
  logic [W-1:0] valid_mem [ROWS];
  entry_t       ent_mem   [SLOTS];
  logic [W-1:0] vrow_q;
  logic         vinit_q;
  entry_t       ent_q;

  logic in_acc;
  logic out_free;
  logic reg_full_in;
  logic req_ok_in;
  logic [SW-1:0] req_slot_in;

  logic [RW-1:0] rd_row;
  logic [RW-1:0] cur_row;
  logic [OW-1:0] cur_off;
  logic [W-1:0]  word;
  logic [W-1:0]  bit_sel;
  logic          wr_en;
  logic [W-1:0]  wr_word;
  logic          ent_we;

  logic [W-1:0]    wf_bits;
  logic            wf_found;
  logic [OW-1:0]   wf_index;
  logic [ROWS-1:0] rf_bits;
  logic            rf_found;
  logic [RW-1:0]   rf_index;

  logic             reg_full;
  logic             do_alloc;
  logic             do_free;
  logic             need_scan;
  logic [OUT_W-1:0] rs_slot;
  logic [OUT_W-1:0] rs_freed;
  logic [ST_W-1:0]  rs_status;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Request decode at accept
  assign reg_full_in = (used_count >= CW'(SLOTS)) || (lowest_free >= CW'(SLOTS));
  always_comb begin
    if (op == OP_REGISTER) begin
      req_slot_in = SW'(lowest_free);
      req_ok_in   = !reg_full_in;
    end else begin
      req_slot_in = SW'(item_index);
      req_ok_in   = (32'(item_index) < SLOTS);
    end
  end

  // Current row fields
  assign cur_row = row_of(req_slot);
  assign cur_off = off_of(req_slot);
  assign word    = vinit_q ? vrow_q : '0;
  assign bit_sel = W'(1) << cur_off;

  // Lowest clear bit: above the allocated slot, or within the scanned row
  assign wf_bits = (state == S_SCAN) ? (word | pad_mask(scan_row))
                                     : (word | bit_sel | pad_mask(cur_row) | low_mask(cur_off));

  // Lowest non-full row above the current one
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      rf_bits[i] = row_full[i] || (i <= int'(cur_row));
    end
  end

  lfs_zero_find #(.N(W)) u_word_find (
    .bits  (wf_bits),
    .found (wf_found),
    .index (wf_index)
  );

  lfs_zero_find #(.N(ROWS)) u_row_find (
    .bits  (rf_bits),
    .found (rf_found),
    .index (rf_index)
  );

  // Outcome of the read-modify-write cycle
  always_comb begin
    reg_full  = (used_count >= CW'(SLOTS)) || (lowest_free >= CW'(SLOTS));
    do_alloc  = 1'b0;
    do_free   = 1'b0;
    need_scan = 1'b0;
    rs_freed  = NONE_INDEX;
    rs_status = ST_OK;
    if (op_q == OP_REGISTER) begin
      if (reg_full) begin
        rs_slot   = OUT_W'(SLOTS);
        rs_status = ST_FULL;
      end else begin
        rs_slot   = OUT_W'(lowest_free);
        do_alloc  = 1'b1;
        need_scan = !wf_found && rf_found;
      end
    end else begin
      rs_slot = OUT_W'(idx_q);
      if (used_count == '0) begin
        rs_status = ST_EMPTY;
      end else if (!req_ok || !word[cur_off]) begin
        rs_status = ST_FREE;
      end else begin
        rs_freed = OUT_W'(ent_q.obj);
        do_free  = 1'b1;
      end
    end
  end

  // Memory write controls
  assign wr_en   = (state == S_RD) && (do_alloc || do_free);
  assign wr_word = do_alloc ? (word | bit_sel) : (word & ~bit_sel);
  assign ent_we  = (state == S_RD) && do_alloc;

  // Read address: request row at accept, else the scan row. The scan row
  // differs from the row written in the same cycle, and the next request
  // reads only after the write has landed.
  always_comb begin
    if (state == S_IDLE) begin
      rd_row = req_ok_in ? row_of(req_slot_in) : '0;
    end else begin
      rd_row = rf_index;
    end
  end

  // Valid-row memory
  always_ff @(posedge clk) begin
    vrow_q  <= valid_mem[rd_row];
    vinit_q <= row_init[rd_row];
    if (wr_en) begin
      valid_mem[cur_row] <= wr_word;
    end
  end

  // Entry memory
  always_ff @(posedge clk) begin
    ent_q <= ent_mem[SW'(item_index)];
    if (ent_we) begin
      ent_mem[req_slot] <= '{kind: type_q, obj: idx_q};
    end
  end

  // Request capture, plus scan row and result in the read state
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q     <= op;
      req_slot <= req_ok_in ? req_slot_in : '0;
      req_ok   <= req_ok_in;
      idx_q    <= item_index;
      type_q   <= obj_type;
    end
    if (state == S_RD) begin
      scan_row   <= rf_index;
      res_slot   <= rs_slot;
      res_freed  <= rs_freed;
      res_status <= rs_status;
    end
  end

  // Sequencer, pointer, count and row flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lowest_free <= '0;
      used_count  <= '0;
      row_full    <= '0;
      row_init    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (do_alloc) begin
            row_init[cur_row] <= 1'b1;
            row_full[cur_row] <= &(word | bit_sel | pad_mask(cur_row));
            used_count        <= used_count + CW'(1);
            if (wf_found) begin
              lowest_free <= slot_at(cur_row, wf_index);
            end else if (!rf_found) begin
              lowest_free <= CW'(SLOTS);
            end
          end
          if (do_free) begin
            row_full[cur_row] <= 1'b0;
            used_count        <= used_count - CW'(1);
            if (lowest_free > CW'(req_slot)) begin
              lowest_free <= CW'(req_slot);
            end
          end
          if (need_scan) begin
            state <= S_SCAN;
          end else if (out_free) begin
            state <= S_IDLE;
          end else begin
            state <= S_OUT;
          end
        end
        S_SCAN: begin
          lowest_free <= slot_at(scan_row, wf_index);
          state       <= out_free ? S_IDLE : S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && (state == S_RD) && !need_scan) begin
      out_valid <= 1'b1;
    end else if (out_free && ((state == S_SCAN) || (state == S_OUT))) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (state == S_RD) && !need_scan) begin
      slot        <= rs_slot;
      freed_index <= rs_freed;
      status      <= rs_status;
    end else if (out_free && ((state == S_SCAN) || (state == S_OUT))) begin
      slot        <= res_slot;
      freed_index <= res_freed;
      status      <= res_status;
    end
  end

  // Checks
  `ASSERT_NEXT(a_accept_reads, in_acc, state == S_RD, "accepted transaction skipped read")
  `ASSERT_NOW(a_scan_hit, state == S_SCAN, wf_found, "non-full row has no free slot")
  `ASSERT_NOW(a_count_range, 1'b1, used_count <= CW'(SLOTS), "used count past capacity")
  `ASSERT_NOW(a_ptr_range, 1'b1, lowest_free <= CW'(SLOTS), "lowest free pointer past end")

endmodule
